### sv/lcar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcar_pkg
// Shared types and constants for the load-cell converter reader.
// ----------------------------------------------------------------------------
package lcar_pkg;

  localparam int OP_W    = 3;
  localparam int CNT_W   = 8;
  localparam int DATA_W  = 24;
  localparam int SUM_W   = 32;
  localparam int PULSE_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_MEASURE = 3'd1,
    OP_TARE    = 3'd2,
    OP_LOAD    = 3'd3,
    OP_PDOWN   = 3'd4,
    OP_PUP     = 3'd5
  } op_t;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_WAIT  = 5'b00010,
    PH_SHIFT = 5'b00100,
    PH_PULSE = 5'b01000,
    PH_DOWN  = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE = 3'b001,
    SQ_DIV  = 3'b010,
    SQ_FIN  = 3'b100
  } seq_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage

### sv/lcar_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcar_cmd_if / lcar_res_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface lcar_cmd_if;
  import lcar_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic              dout_level;
  logic [CNT_W-1:0]  average_count;
  logic [DATA_W-1:0] offset_value;

  modport source (output valid, operation, dout_level, average_count, offset_value,
                  input ready);
  modport sink (input valid, operation, dout_level, average_count, offset_value,
                output ready);
endinterface

interface lcar_res_if;
  import lcar_pkg::*;

  logic              valid;
  logic              ready;
  logic              sck_level;
  logic              busy_res;
  logic              result_valid;
  logic [DATA_W-1:0] raw_average;
  logic [DATA_W-1:0] net_value;

  modport source (output valid, sck_level, busy_res, result_valid, raw_average,
                  net_value, input ready);
  modport sink (input valid, sck_level, busy_res, result_valid, raw_average,
                net_value, output ready);
endinterface

### sv/lcar_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcar_div
// Restoring divider, one quotient bit per cycle, for the run average.
// ----------------------------------------------------------------------------
module lcar_div (
  input  logic                     clk,
  input  logic                     rst,
  input  lcar_pkg::div_req_t       req,
  output logic                     done,
  output logic [lcar_pkg::SUM_W-1:0] quotient
);
  import lcar_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W:0]    rem;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  dvsr;
  logic [CNT_W:0]    rem_shift;
  logic [CNT_W:0]    diff;
  logic              fits;

  always_comb begin
    rem_shift = {rem[CNT_W-1:0], quo[SUM_W-1]};
    fits      = rem_shift >= {1'b0, dvsr};
    diff      = rem_shift - {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dvsr <= (req.divisor == '0) ? CNT_W'(1) : req.divisor;
      end else if (busy) begin
        rem  <= fits ? diff : rem_shift;
        quo  <= {quo[SUM_W-2:0], fits};
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

### sv/load_cell_adc_reader_tare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_adc_reader_tare
// Two-wire load-cell converter master with averaging and tare offset.
// ----------------------------------------------------------------------------
// Every command beat yields exactly one result beat. A beat that does not end
// a measurement or tare run gives its result in the cycle after acceptance,
// and the next beat may be taken in that same cycle if res.ready is high. A
// beat that ends a run has its run sum divided by the sample count in a shared
// restoring divider that produces one quotient bit per cycle over 32 steps;
// then the sequencer sees the divider finish in SQ_DIV and forms the net
// value in SQ_FIN. No command is taken while the divider runs or while a
// finished result waits on the output register.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_tare #(
  parameter int SAMPLE_BITS  = 24,
  parameter int TARE_SAMPLES = 50
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lcar_pkg::PULSE_W-1:0]  cfg_wr_data,
  lcar_cmd_if.sink                      cmd,
  lcar_res_if.source                    res
);
  import lcar_pkg::*;

  localparam int BC_W = $clog2(SAMPLE_BITS + 1);
  localparam logic [SAMPLE_BITS-1:0] TOP_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [PULSE_W-1:0]     extra_pulses;
  phase_t                 phase, phase_next;
  logic [BC_W-1:0]        bit_counter, bit_counter_next;
  logic [SAMPLE_BITS-1:0] shift_word, shift_word_next;
  logic [SUM_W-1:0]       running_sum, running_sum_next;
  logic [CNT_W-1:0]       samples_done, samples_done_next;
  logic [CNT_W-1:0]       samples_wanted, samples_wanted_next;
  logic                   tare_run, tare_run_next;
  logic [DATA_W-1:0]      tare_offset, tare_offset_next;
  logic                   clock_high, clock_high_next;

  seq_t                   seq;
  logic                   pend_tare;
  logic                   pend_sck;

  logic                   out_valid;
  logic                   out_sck;
  logic                   out_busy;
  logic                   out_done;
  logic [DATA_W-1:0]      out_avg;
  logic [DATA_W-1:0]      out_net;

  logic                   accept;
  logic                   out_free;
  logic                   done_now;
  logic                   end_conv;
  logic [SAMPLE_BITS-1:0] conv_word;
  logic [BC_W-1:0]        bc_inc;
  logic [CNT_W-1:0]       done_inc;
  op_t                    op;

  div_req_t               div_req;
  logic                   div_done;
  logic [SUM_W-1:0]       div_quo;
  logic [DATA_W-1:0]      avg;
  logic [DATA_W-1:0]      net;

  assign out_free  = !out_valid || res.ready;
  assign cmd.ready = (seq == SQ_IDLE) && out_free;
  assign accept    = cmd.valid && cmd.ready;
  assign op        = op_t'(cmd.operation);

  always_comb begin
    phase_next          = phase;
    bit_counter_next    = bit_counter;
    shift_word_next     = shift_word;
    running_sum_next    = running_sum;
    samples_done_next   = samples_done;
    samples_wanted_next = samples_wanted;
    tare_run_next       = tare_run;
    tare_offset_next    = tare_offset;
    clock_high_next     = clock_high;
    end_conv            = 1'b0;
    done_now            = 1'b0;
    conv_word           = shift_word;
    bc_inc              = bit_counter + 1'b1;
    done_inc            = samples_done + 1'b1;

    unique case (op) inside
      OP_MEASURE, OP_TARE: begin
        if (op == OP_TARE) begin
          samples_wanted_next = CNT_W'(TARE_SAMPLES);
        end else begin
          samples_wanted_next = (cmd.average_count == '0) ? CNT_W'(1) : cmd.average_count;
        end
        samples_done_next = '0;
        running_sum_next  = '0;
        tare_run_next     = (op == OP_TARE);
        bit_counter_next  = '0;
        shift_word_next   = '0;
        clock_high_next   = 1'b0;
        phase_next        = PH_WAIT;
      end
      OP_LOAD: begin
        tare_offset_next = cmd.offset_value;
      end
      OP_PDOWN: begin
        phase_next       = PH_DOWN;
        clock_high_next  = 1'b1;
        bit_counter_next = '0;
        shift_word_next  = '0;
      end
      OP_PUP: begin
        if (phase == PH_DOWN) begin
          phase_next      = PH_IDLE;
          clock_high_next = 1'b0;
        end
      end
      OP_TICK: begin
        unique case (phase) inside
          PH_WAIT: begin
            if (!cmd.dout_level) begin
              phase_next       = PH_SHIFT;
              bit_counter_next = '0;
              shift_word_next  = '0;
              clock_high_next  = 1'b1;
            end
          end
          PH_SHIFT: begin
            if (!clock_high) begin
              clock_high_next = 1'b1;
            end else begin
              clock_high_next = 1'b0;
              shift_word_next = {shift_word[SAMPLE_BITS-2:0], cmd.dout_level};
              conv_word       = shift_word_next;
              if (bc_inc >= BC_W'(SAMPLE_BITS)) begin
                bit_counter_next = '0;
                if (extra_pulses == '0) begin
                  end_conv = 1'b1;
                end else begin
                  phase_next = PH_PULSE;
                end
              end else begin
                bit_counter_next = bc_inc;
              end
            end
          end
          PH_PULSE: begin
            if (!clock_high) begin
              clock_high_next = 1'b1;
            end else begin
              clock_high_next = 1'b0;
              if (bc_inc >= BC_W'(extra_pulses)) begin
                end_conv = 1'b1;
              end else begin
                bit_counter_next = bc_inc;
              end
            end
          end
          PH_IDLE, PH_DOWN: begin
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    if (end_conv) begin
      running_sum_next  = running_sum + SUM_W'(conv_word ^ TOP_BIT);
      samples_done_next = done_inc;
      bit_counter_next  = '0;
      shift_word_next   = '0;
      if (done_inc >= samples_wanted) begin
        phase_next    = PH_IDLE;
        done_now      = 1'b1;
        tare_run_next = 1'b0;
      end else begin
        phase_next = PH_WAIT;
      end
    end
  end

  assign div_req.start    = accept && done_now;
  assign div_req.dividend = running_sum_next;
  assign div_req.divisor  = samples_wanted;

  lcar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign avg = div_quo[DATA_W-1:0];
  assign net = (!pend_tare && (avg < tare_offset)) ? (tare_offset - avg) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      extra_pulses   <= PULSE_W'(1);
      phase          <= PH_IDLE;
      bit_counter    <= '0;
      shift_word     <= '0;
      running_sum    <= '0;
      samples_done   <= '0;
      samples_wanted <= '0;
      tare_run       <= 1'b0;
      tare_offset    <= '0;
      clock_high     <= 1'b0;
      seq            <= SQ_IDLE;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        extra_pulses <= cfg_wr_data;
      end
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end

      unique case (seq)
        SQ_IDLE: begin
          if (accept) begin
            phase          <= phase_next;
            bit_counter    <= bit_counter_next;
            shift_word     <= shift_word_next;
            running_sum    <= running_sum_next;
            samples_done   <= samples_done_next;
            samples_wanted <= samples_wanted_next;
            tare_run       <= tare_run_next;
            tare_offset    <= tare_offset_next;
            clock_high     <= clock_high_next;
            if (done_now) begin
              pend_tare <= tare_run;
              pend_sck  <= clock_high_next;
              seq       <= SQ_DIV;
            end else begin
              out_valid <= 1'b1;
              out_sck   <= clock_high_next;
              out_busy  <= (phase_next == PH_WAIT) || (phase_next == PH_SHIFT) ||
                           (phase_next == PH_PULSE);
              out_done  <= 1'b0;
              out_avg   <= '0;
              out_net   <= '0;
            end
          end
        end
        SQ_DIV: begin
          if (div_done) begin
            seq <= SQ_FIN;
          end
        end
        SQ_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_sck   <= pend_sck;
            out_busy  <= 1'b0;
            out_done  <= 1'b1;
            out_avg   <= avg;
            out_net   <= net;
            if (pend_tare) begin
              tare_offset <= avg;
            end
            seq <= SQ_IDLE;
          end
        end
        default: begin
          seq <= SQ_IDLE;
        end
      endcase
    end
  end

  assign res.valid        = out_valid;
  assign res.sck_level    = out_sck;
  assign res.busy_res     = out_busy;
  assign res.result_valid = out_done;
  assign res.raw_average  = out_avg;
  assign res.net_value    = out_net;

endmodule
